// ----- rtl/hels_pkg.sv -----
// ----------------------------------------------------------------------------
// hels_pkg
// Shared constants and arithmetic helpers for the heat element local system.
// ----------------------------------------------------------------------------
package hels_pkg;

    localparam int NODES_DEF = 4;
    localparam int DIM_DEF   = 2;

    localparam logic [0:0] REG_CONDUCTIVITY = 1'd0;
    localparam logic [0:0] REG_INV_DT       = 1'd1;

    localparam logic [31:0] Q_ONE = 32'sd65536;

    localparam logic KIND_MATRIX   = 1'b0;
    localparam logic KIND_RESIDUAL = 1'b1;

    // saturate a wide signed value to 32 bits
    function automatic logic [32:0] sat32(input logic signed [79:0] v);
        logic [32:0] r;
        if (v > 80'sd2147483647)
            r = {1'b1, 32'h7fffffff};
        else if (v < -80'sd2147483648)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // round a Q32.32 product to Q16.16 (floor after adding half), saturated
    function automatic logic [32:0] rnd_sat(input logic signed [63:0] p);
        logic signed [79:0] t;
        t = (80'(p) + 80'sd32768) >>> 16;
        return sat32(t);
    endfunction

endpackage

// ----- rtl/hels_mac.sv -----
// ----------------------------------------------------------------------------
// hels_mac
// Registered 32x32 signed multiplier with rounding and saturation.
// ----------------------------------------------------------------------------
module hels_mac
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] q,
    output logic               sat
);

    logic signed [63:0] prod_reg;
    logic [32:0]        rs;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign rs  = hels_pkg::rnd_sat(prod_reg);
    assign q   = rs[31:0];
    assign sat = rs[32];

endmodule

// ----- rtl/heat_element_local_system_core.sv -----
// ----------------------------------------------------------------------------
// heat_element_local_system_core
// Backward Euler heat element assembly: matrix then residual, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one node transaction at a time;
//   the node words are written to a node memory. point_weight and
//   source_flux are latched from the first node of an element.
//   When last_node is set, or NODES nodes have arrived, the block computes
//   n*n matrix entries row-major, then n residual entries, and sends each
//   on the output channel (out_valid/out_stall). last_entry marks the final
//   residual entry. Input is stalled while an element is being computed.
//   Each result is formed by a sequencer around one registered multiplier;
//   each product passes through a read, a multiply and an accumulate
//   state. A matrix entry takes DIM+3 products, a residual entry n+3, and
//   a closing node passes through S_TP and S_PRE before the first entry.
//   Output stalls hold the sequencer.
//   Reset clears control state and sets both registers to 1.0. A stalled
//   output holds its transaction until taken; the sequencer waits.
// ----------------------------------------------------------------------------
module heat_element_local_system_core
#(
    parameter int NODES = hels_pkg::NODES_DEF,
    parameter int DIM   = hels_pkg::DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] shape_value,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    input  logic signed [31:0] grad_z,
    input  logic signed [31:0] temp_previous,
    input  logic signed [31:0] temp_current,
    input  logic signed [31:0] point_weight,
    input  logic signed [31:0] source_flux,
    input  logic               last_node,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               entry_kind,
    output logic [2:0]         row_index,
    output logic [2:0]         column_index,
    output logic signed [31:0] entry_value,
    output logic               saturated,
    output logic               last_entry
);

    localparam int NW  = NODES * 5;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int MD  = NODES * NODES;
    localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

    // sequencer states
    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_TP   = 4'd1;  // prev temp product wait
    localparam logic [3:0] S_PRE  = 4'd2;  // wk, wdt, wq
    localparam logic [3:0] S_MRD  = 4'd3;  // issue memory reads
    localparam logic [3:0] S_MMUL = 4'd4;  // multiply
    localparam logic [3:0] S_MACC = 4'd5;  // take product
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_RRD  = 4'd7;
    localparam logic [3:0] S_RMUL = 4'd8;
    localparam logic [3:0] S_RACC = 4'd9;

    logic [3:0] state_reg;

    logic signed [31:0] k_reg, idt_reg;
    logic signed [31:0] w_reg, q_reg;
    logic signed [47:0] acc_tp_reg;
    logic [2:0]         cnt_reg;     // nodes loaded
    logic [2:0]         n_reg;
    logic [2:0]         i_reg, j_reg;
    logic [2:0]         step_reg;    // step inside one entry
    logic signed [31:0] wk_reg, wdt_reg, wq_reg, tp_reg;
    logic               fw_reg, fm_reg, fs_reg, ft_reg;
    logic signed [79:0] sum_reg;     // exact accumulator
    logic signed [31:0] tmp_reg;     // intermediate operand
    logic               f_reg;

    // node memory: per node N, gx, gy, gz, Tcur
    logic signed [31:0] nmem [NW];
    logic signed [31:0] nrd_a_reg, nrd_b_reg;
    logic [AW-1:0]      ra_a, ra_b;
    logic signed [31:0] mmem [MD];
    logic signed [31:0] mrd_reg;
    logic [MAW-1:0]     mra;
    logic               mwe;
    logic [MAW-1:0]     mwa;
    logic signed [31:0] mwd;

    // multiplier
    logic signed [31:0] ma, mb, mq;
    logic               msat;

    hels_mac u_mac (.clk(clk), .a(ma), .b(mb), .q(mq), .sat(msat));

    logic in_acc, out_acc;
    assign in_stall = (state_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    function automatic logic [AW-1:0] naddr(input logic [2:0] node, input int w);
        return AW'(32'(node) * 5 + w);
    endfunction

    // node memory write and reads
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            nmem[naddr(cnt_reg, 0)] <= shape_value;
            nmem[naddr(cnt_reg, 1)] <= grad_x;
            nmem[naddr(cnt_reg, 2)] <= grad_y;
            nmem[naddr(cnt_reg, 3)] <= grad_z;
            nmem[naddr(cnt_reg, 4)] <= temp_current;
        end
        nrd_a_reg <= nmem[ra_a];
        nrd_b_reg <= nmem[ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
            mmem[mwa] <= mwd;
        mrd_reg <= mmem[mra];
    end

    // saturation of the wide sums
    logic signed [79:0] mq_ext;
    logic [32:0]        sum_sat;
    logic signed [79:0] res_sum;
    logic [32:0]        res_sat;
    logic [32:0]        mat_sat;
    logic [32:0]        tp_sat;
    assign mq_ext  = 80'(mq);
    assign sum_sat = hels_pkg::sat32(sum_reg);
    assign res_sum = sum_reg - mq_ext;
    assign res_sat = hels_pkg::sat32(res_sum);
    assign mat_sat = hels_pkg::sat32(sum_reg + mq_ext);
    assign tp_sat  = hels_pkg::sat32(80'(acc_tp_reg));

    // step plan for matrix entry:
    //  steps 0..DIM-1 : g_d products (operands gi_d, gj_d)
    //  step DIM       : wk*G
    //  step DIM+1     : Ni*Nj
    //  step DIM+2     : wdt*NN
    // residual entry:
    //  step 0 : wq*Ni -> sum
    //  step 1 : wdt*Ni -> tmp
    //  step 2 : tmp*tp -> sum
    //  step 3 : L_ij*Tcur_j for j=0..n-1 -> subtract (step held, j advances)
    logic last_in;
    assign last_in = last_node || (cnt_reg == 3'(NODES - 1));

    always_comb
    begin
        ra_a = naddr(i_reg, 0);
        ra_b = naddr(j_reg, 0);
        mra  = MAW'(32'(i_reg) * NODES + 32'(j_reg));
        ma   = '0;
        mb   = '0;
        if (state_reg == S_MRD)
        begin
            if (step_reg < 3'(DIM))
            begin
                ra_a = naddr(i_reg, 1 + int'(step_reg));
                ra_b = naddr(j_reg, 1 + int'(step_reg));
            end
        end
        if (state_reg == S_RRD && step_reg >= 3'd3)
            ra_b = naddr(j_reg, 4);
        case (state_reg)
            S_LOAD:
            begin
                ma = shape_value;
                mb = temp_previous;
            end
            S_PRE:
            begin
                ma = w_reg;
                mb = (step_reg == 3'd0) ? k_reg : (step_reg == 3'd1) ? idt_reg : q_reg;
            end
            S_MMUL:
            begin
                if (step_reg < 3'(DIM))
                begin
                    ma = nrd_a_reg;
                    mb = nrd_b_reg;
                end
                else if (step_reg == 3'(DIM))
                begin
                    ma = wk_reg;
                    mb = sum_sat[31:0];
                end
                else if (step_reg == 3'(DIM + 1))
                begin
                    ma = nrd_a_reg;
                    mb = nrd_b_reg;
                end
                else
                begin
                    ma = wdt_reg;
                    mb = tmp_reg;
                end
            end
            S_RMUL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma = wq_reg;
                        mb = nrd_a_reg;
                    end
                    3'd1:
                    begin
                        ma = wdt_reg;
                        mb = nrd_a_reg;
                    end
                    3'd2:
                    begin
                        ma = tmp_reg;
                        mb = tp_reg;
                    end
                    default:
                    begin
                        ma = mrd_reg;
                        mb = nrd_b_reg;
                    end
                endcase
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // output register
    logic               ov_reg, okind_reg, osat_reg, olast_reg;
    logic [2:0]         orow_reg, ocol_reg;
    logic signed [31:0] oval_reg;

    assign out_valid    = ov_reg;
    assign entry_kind   = okind_reg;
    assign row_index    = orow_reg;
    assign column_index = ocol_reg;
    assign entry_value  = oval_reg;
    assign saturated    = osat_reg;
    assign last_entry   = olast_reg;

    always_comb
    begin
        mwe = (state_reg == S_MACC) && (step_reg == 3'(DIM + 2));
        mwa = MAW'(32'(i_reg) * NODES + 32'(j_reg));
        mwd = mat_sat[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            k_reg      <= hels_pkg::Q_ONE;
            idt_reg    <= hels_pkg::Q_ONE;
            w_reg      <= '0;
            q_reg      <= '0;
            acc_tp_reg <= '0;
            cnt_reg    <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            step_reg   <= '0;
            ov_reg     <= 1'b0;
            okind_reg  <= 1'b0;
            olast_reg  <= 1'b0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            osat_reg   <= 1'b0;
            oval_reg   <= '0;
            fw_reg     <= 1'b0;
            fm_reg     <= 1'b0;
            fs_reg     <= 1'b0;
            ft_reg     <= 1'b0;
            f_reg      <= 1'b0;
            sum_reg    <= '0;
            tmp_reg    <= '0;
            wk_reg     <= '0;
            wdt_reg    <= '0;
            wq_reg     <= '0;
            tp_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == hels_pkg::REG_CONDUCTIVITY)
                    k_reg <= cfg_data;
                else
                    idt_reg <= cfg_data;
            end
            if (out_acc)
                ov_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (cnt_reg == 3'd0)
                        begin
                            w_reg <= point_weight;
                            q_reg <= source_flux;
                        end
                        n_reg     <= cnt_reg + 3'd1;
                        step_reg  <= {2'b0, last_in};
                        state_reg <= S_TP;
                    end
                end
                S_TP:
                begin
                    // product of N and Tprev is ready now
                    acc_tp_reg <= ((n_reg == 3'd1) ? 48'sd0 : acc_tp_reg) + 48'(mq);
                    if (step_reg[0])
                    begin
                        cnt_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_PRE;
                    end
                    else
                    begin
                        cnt_reg   <= n_reg;
                        state_reg <= S_LOAD;
                    end
                end
                S_PRE:
                begin
                    // issue operands at steps 0..2, collect results at 1..3
                    case (step_reg)
                        3'd1:
                        begin
                            wk_reg <= mq;
                            fw_reg <= msat;
                        end
                        3'd2:
                        begin
                            wdt_reg <= mq;
                            fm_reg  <= msat;
                        end
                        3'd3:
                        begin
                            wq_reg <= mq;
                            fs_reg <= msat;
                        end
                        default:
                        begin
                            tp_reg <= tp_sat[31:0];
                            ft_reg <= tp_sat[32];
                        end
                    endcase
                    if (step_reg == 3'd3)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        step_reg  <= '0;
                        sum_reg   <= '0;
                        f_reg     <= fw_reg || fm_reg;
                        state_reg <= S_MRD;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end
                S_MRD:
                    state_reg <= S_MMUL;
                S_MMUL:
                    state_reg <= S_MACC;
                S_MACC:
                begin
                    state_reg <= S_MRD;
                    step_reg  <= step_reg + 3'd1;
                    if (step_reg < 3'(DIM))
                    begin
                        sum_reg <= sum_reg + mq_ext;
                        f_reg   <= f_reg | msat;
                    end
                    else if (step_reg == 3'(DIM))
                    begin
                        // G saturation already applied in operand; record flag
                        sum_reg <= mq_ext;
                        f_reg   <= f_reg | msat | sum_sat[32];
                    end
                    else if (step_reg == 3'(DIM + 1))
                    begin
                        tmp_reg <= mq;
                        f_reg   <= f_reg | msat;
                    end
                    else
                    begin
                        ov_reg    <= 1'b1;
                        okind_reg <= hels_pkg::KIND_MATRIX;
                        orow_reg  <= i_reg;
                        ocol_reg  <= j_reg;
                        oval_reg  <= mwd;
                        osat_reg  <= f_reg | msat | mat_sat[32];
                        olast_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || out_acc)
                    begin
                        step_reg <= '0;
                        sum_reg  <= '0;
                        if (okind_reg == hels_pkg::KIND_MATRIX)
                        begin
                            if (j_reg + 3'd1 < n_reg)
                            begin
                                j_reg     <= j_reg + 3'd1;
                                f_reg     <= fw_reg || fm_reg;
                                state_reg <= S_MRD;
                            end
                            else if (i_reg + 3'd1 < n_reg)
                            begin
                                i_reg     <= i_reg + 3'd1;
                                j_reg     <= '0;
                                f_reg     <= fw_reg || fm_reg;
                                state_reg <= S_MRD;
                            end
                            else
                            begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                f_reg     <= fs_reg || fm_reg || ft_reg;
                                state_reg <= S_RRD;
                            end
                        end
                        else if (i_reg + 3'd1 < n_reg)
                        begin
                            i_reg     <= i_reg + 3'd1;
                            j_reg     <= '0;
                            f_reg     <= fs_reg || fm_reg || ft_reg;
                            state_reg <= S_RRD;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                            okind_reg <= hels_pkg::KIND_MATRIX;
                        end
                    end
                end
                S_RRD:
                    state_reg <= S_RMUL;
                S_RMUL:
                    state_reg <= S_RACC;
                S_RACC:
                begin
                    state_reg <= S_RRD;
                    step_reg  <= step_reg + 3'd1;
                    f_reg     <= f_reg | msat;
                    case (step_reg)
                        3'd0:
                            sum_reg <= mq_ext;
                        3'd1:
                            tmp_reg <= mq;
                        3'd2:
                            sum_reg <= sum_reg + mq_ext;
                        default:
                        begin
                            // coupling terms stay on step 3; j walks the columns
                            step_reg <= 3'd3;
                            sum_reg  <= res_sum;
                            if (j_reg + 3'd1 < n_reg)
                                j_reg <= j_reg + 3'd1;
                            else
                            begin
                                ov_reg    <= 1'b1;
                                okind_reg <= hels_pkg::KIND_RESIDUAL;
                                orow_reg  <= i_reg;
                                ocol_reg  <= '0;
                                oval_reg  <= res_sat[31:0];
                                osat_reg  <= f_reg | msat | res_sat[32];
                                olast_reg <= (i_reg + 3'd1 == n_reg);
                                state_reg <= S_OUT;
                            end
                        end
                    endcase
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heat_element_local_system_core. Node transactions
// go into an element assembly predictor, which queues the expected matrix and
// residual entries. Each output transaction is compared against the oldest
// queued entry. Both sides pause at random, and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NODES    = hels_pkg::NODES_DEF;
    localparam int DIM      = hels_pkg::DIM_DEF;
    localparam int IDLE_MAX = 6000;

    typedef struct {
        bit          kind;
        bit [2:0]    row;
        bit [2:0]    col;
        logic [31:0] value;
        bit          sat;
        bit          last;
    } entry_t;

    class element_scoreboard;
        longint k_reg;
        longint inv_dt;
        longint nodes [NODES][5];
        longint lhs [NODES][NODES];
        int     count;
        longint tprev_acc;
        longint weight;
        longint flux;
        entry_t entries [$];
        int     errors;

        function new();
            k_reg = hels_pkg::Q_ONE;
            inv_dt = hels_pkg::Q_ONE;
            count = 0;
            tprev_acc = 0;
            weight = 0;
            flux = 0;
            errors = 0;
        endfunction

        function longint clip(longint v, ref bit f);
            if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function longint qmul(longint a, longint b, ref bit f);
            return clip((a * b + 32768) >>> 16, f);
        endfunction

        function void push(bit kind, int r, int c, longint v, bit s, bit l);
            entry_t e;
            e.kind = kind; e.row = 3'(r); e.col = 3'(c); e.value = v[31:0];
            e.sat = s; e.last = l;
            entries.push_back(e);
        endfunction

        function void note_node(longint sv, longint gx, longint gy, longint gz,
                                longint tp, longint tc, longint pw, longint sf,
                                bit last);
            bit     dummy, fw, fm, fs, ft, f;
            longint wk, wdt, wq, tpv, g, v, ni, src, hist, cpl;
            int     idx, n;
            dummy = 0; fw = 0; fm = 0; fs = 0; ft = 0;
            if (count >= NODES)
                count = 0;
            idx = count;
            nodes[idx][0] = sv; nodes[idx][1] = gx; nodes[idx][2] = gy;
            nodes[idx][3] = gz; nodes[idx][4] = tc;
            if (idx == 0)
            begin
                weight = pw;
                flux = sf;
                tprev_acc = 0;
            end
            tprev_acc += qmul(sv, tp, dummy);
            count = idx + 1;
            if (!last && count < NODES)
                return;
            n = count;
            wk  = qmul(weight, k_reg, fw);
            wdt = qmul(weight, inv_dt, fm);
            wq  = qmul(weight, flux, fs);
            tpv = clip(tprev_acc, ft);
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    f = fw | fm;
                    g = 0;
                    for (int d = 0; d < DIM && d < 3; d++)
                        g += qmul(nodes[i][1 + d], nodes[j][1 + d], f);
                    g = clip(g, f);
                    v = clip(qmul(wk, g, f)
                             + qmul(wdt, qmul(nodes[i][0], nodes[j][0], f), f), f);
                    lhs[i][j] = v;
                    push(hels_pkg::KIND_MATRIX, i, j, v, f, 0);
                end
            for (int i = 0; i < n; i++)
            begin
                f = fs | fm | ft;
                ni = nodes[i][0];
                src = qmul(wq, ni, f);
                hist = qmul(qmul(wdt, ni, f), tpv, f);
                cpl = 0;
                for (int j = 0; j < n; j++)
                    cpl += qmul(lhs[i][j], nodes[j][4], f);
                v = clip(src + hist - cpl, f);
                push(hels_pkg::KIND_RESIDUAL, i, 0, v, f, i + 1 == n);
            end
            count = 0;
            tprev_acc = 0;
        endfunction

        function void check_entry(entry_t got);
            entry_t e;
            if (entries.size() == 0)
            begin
                $error("unexpected entry row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            e = entries.pop_front();
            if (got.kind !== e.kind)
            begin $error("entry_kind exp %0d got %0d", e.kind, got.kind); errors++; end
            if (got.row !== e.row)
            begin $error("row_index exp %0d got %0d", e.row, got.row); errors++; end
            if (got.col !== e.col)
            begin $error("column_index exp %0d got %0d", e.col, got.col); errors++; end
            if (got.value !== e.value)
            begin $error("entry_value exp %h got %h", e.value, got.value); errors++; end
            if (got.sat !== e.sat)
            begin $error("saturated exp %0d got %0d", e.sat, got.sat); errors++; end
            if (got.last !== e.last)
            begin $error("last_entry exp %0d got %0d", e.last, got.last); errors++; end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] shape_value, grad_x, grad_y, grad_z;
    logic signed [31:0] temp_previous, temp_current, point_weight, source_flux;
    logic               last_node;
    logic               out_valid;
    logic               out_stall;
    logic               entry_kind;
    logic [2:0]         row_index, column_index;
    logic signed [31:0] entry_value;
    logic               saturated, last_entry;

    element_scoreboard sb = new();
    int idle_cycles = 0;
    int results_seen = 0;

    heat_element_local_system_core #(.NODES(NODES), .DIM(DIM)) i_dut (.*);

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            entry_t got;
            got.kind = entry_kind; got.row = row_index; got.col = column_index;
            got.value = entry_value; got.sat = saturated; got.last = last_entry;
            sb.check_entry(got);
            results_seen++;
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int  len;
        bit  held;
        held = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= 40)
            begin
                held = 1;
                len = 500;
            end
            else if ($urandom_range(0, 9) < 6)
                len = 0;
            else if ($urandom_range(0, 9) < 8)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(20, 60);
            if (len > 0)
            begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (len - 1) @(negedge clk);
                @(negedge clk) out_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 40))
                @(negedge clk);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom;
            4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == hels_pkg::REG_CONDUCTIVITY)
            sb.k_reg = longint'(signed'(val));
        else
            sb.inv_dt = longint'(signed'(val));
    endtask

    task automatic send_node(logic [31:0] sv, gx, gy, gz, tp, tc, pw, sf, logic last);
        int gap;
        @(negedge clk);
        shape_value <= sv; grad_x <= gx; grad_y <= gy; grad_z <= gz;
        temp_previous <= tp; temp_current <= tc; point_weight <= pw;
        source_flux <= sf; last_node <= last; in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_node(signed'(sv), signed'(gx), signed'(gy), signed'(gz), signed'(tp),
                     signed'(tc), signed'(pw), signed'(sf), last);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        else if ($urandom_range(0, 9) < 8)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(15, 50);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
    endtask

    task automatic send_random(logic last);
        send_node(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value(), last);
    endtask

    // element with random content; n nodes, the last one marked when mark is set
    task automatic send_element(int n, bit mark);
        for (int i = 0; i < n; i++)
            send_random(mark && (i == n - 1));
    endtask

    task automatic drain();
        if (sb.count != 0)
            send_random(1'b1);
        // withdraw the last offer so it is not taken twice
        @(negedge clk) in_valid <= 1'b0;
        while (sb.entries.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] k_set [5];
        logic [31:0] dt_set [5];
        int          items;
        k_set  = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00008000, 32'hfffe0000};
        dt_set = '{32'h80000000, 32'h7fffffff, 32'h00030000, 32'h0, 32'h00010000};
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        in_valid = 1'b0; last_node = 1'b0;
        shape_value = '0; grad_x = '0; grad_y = '0; grad_z = '0;
        temp_previous = '0; temp_current = '0; point_weight = '0; source_flux = '0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed, reset registers: unit element, extremes, short and full elements
        send_node(hels_pkg::Q_ONE, hels_pkg::Q_ONE, hels_pkg::Q_ONE, hels_pkg::Q_ONE,
                  hels_pkg::Q_ONE, hels_pkg::Q_ONE, hels_pkg::Q_ONE, hels_pkg::Q_ONE,
                  1'b1);
        send_node(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1);
        send_node(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1);
        send_node('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        send_element(2, 1);
        send_element(3, 1);
        send_element(NODES, 0);
        send_element(NODES, 1);
        for (int i = 0; i < NODES; i++)
            send_node(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, '0,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        drain();

        items = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(hels_pkg::REG_CONDUCTIVITY, k_set[ph]);
            write_reg(hels_pkg::REG_INV_DT, dt_set[ph]);
            while (items < (ph + 1) * 50)
            begin
                int n;
                n = $urandom_range(1, NODES);
                case ($urandom_range(0, 9))
                    0: send_element(NODES, 0);
                    1:
                    begin
                        send_random(1'($urandom_range(0, 1)));
                        n = 1;
                    end
                    default: send_element(n, 1);
                endcase
                items += n;
            end
            drain();
        end
        write_reg(hels_pkg::REG_CONDUCTIVITY, hels_pkg::Q_ONE);
        write_reg(hels_pkg::REG_INV_DT, hels_pkg::Q_ONE);
        send_element(NODES, 1);
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.entries.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/hels_pkg.sv
rtl/hels_mac.sv
rtl/heat_element_local_system_core.sv
verif/tb_top.sv
